// File: design/ata_pkg.sv
// Shared types and constants for the accelerometer tilt angle unit.
package ata_pkg;

  localparam int SQRT_STEPS = 32;
  localparam int NUM_LANES  = 2;
  localparam int LANE_ROLL  = 0;
  localparam int LANE_PITCH = 1;
  localparam int ATAN_LEN   = 24;
  localparam int XW         = 35;
  localparam int AW         = 33;

  typedef logic signed [AW-1:0] ang_t;
  typedef logic signed [XW-1:0] vec_t;

  localparam logic signed [16:0] DEG90_Q8   = 17'sd23040;
  localparam ang_t               ROUND_HALF = 33'sd32768;

  localparam ang_t ATAN_DEG_Q24 [ATAN_LEN] = '{
    33'sd754974720, 33'sd445687602, 33'sd235489088, 33'sd119537938,
    33'sd60000934,  33'sd30029717,  33'sd15018523,  33'sd7509720,
    33'sd3754917,   33'sd1877466,   33'sd938734,    33'sd469367,
    33'sd234684,    33'sd117342,    33'sd58671,     33'sd29335,
    33'sd14668,     33'sd7334,      33'sd3667,      33'sd1833,
    33'sd917,       33'sd458,       33'sd229,       33'sd115
  };

  typedef struct packed {
    logic [31:0]        rad;
    logic [33:0]        rem;
    logic [31:0]        root;
    logic signed [15:0] num;
    logic               den_zero;
  } sqrt_lane_t;

  typedef sqrt_lane_t [NUM_LANES-1:0] sqrt_pair_t;

  typedef struct packed {
    vec_t x;
    vec_t y;
    ang_t ang;
    logic den_zero;
    logic num_zero;
    logic num_neg;
  } cordic_lane_t;

  typedef cordic_lane_t [NUM_LANES-1:0] cordic_pair_t;

endpackage

// File: design/ata_sqrt_cell.sv
// One digit step of the pipelined square root, for both angle lanes.
module ata_sqrt_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  ata_pkg::sqrt_pair_t in_lanes,
  output logic              out_valid,
  output ata_pkg::sqrt_pair_t out_lanes
);
  import ata_pkg::*;

  logic       valid_r;
  sqrt_pair_t lanes_r;
  sqrt_pair_t lanes_nxt;
  logic [35:0] cand  [NUM_LANES];
  logic [35:0] trial [NUM_LANES];
  logic [35:0] diff  [NUM_LANES];

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      cand[l]  = {in_lanes[l].rem, in_lanes[l].rad[31:30]};
      trial[l] = {2'b00, in_lanes[l].root, 2'b01};
      diff[l]  = cand[l] - trial[l];
      lanes_nxt[l]     = in_lanes[l];
      lanes_nxt[l].rad = {in_lanes[l].rad[29:0], 2'b00};
      if (cand[l] >= trial[l]) begin
        lanes_nxt[l].rem  = diff[l][33:0];
        lanes_nxt[l].root = {in_lanes[l].root[30:0], 1'b1};
      end else begin
        lanes_nxt[l].rem  = cand[l][33:0];
        lanes_nxt[l].root = {in_lanes[l].root[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    lanes_r <= lanes_nxt;
  end

  assign out_valid = valid_r;
  assign out_lanes = lanes_r;

endmodule

// File: design/ata_cordic_cell.sv
// One vectoring CORDIC rotation step, for both angle lanes.
module ata_cordic_cell #(
  parameter int IDX = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  ata_pkg::cordic_pair_t in_lanes,
  output logic                out_valid,
  output ata_pkg::cordic_pair_t out_lanes
);
  import ata_pkg::*;

  logic         valid_r;
  cordic_pair_t lanes_r;
  cordic_pair_t lanes_nxt;
  vec_t         dx [NUM_LANES];
  vec_t         dy [NUM_LANES];

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      dx[l] = in_lanes[l].y >>> IDX;
      dy[l] = in_lanes[l].x >>> IDX;
      lanes_nxt[l] = in_lanes[l];
      if (!in_lanes[l].y[XW-1]) begin
        lanes_nxt[l].x   = in_lanes[l].x + dx[l];
        lanes_nxt[l].y   = in_lanes[l].y - dy[l];
        lanes_nxt[l].ang = in_lanes[l].ang + ATAN_DEG_Q24[IDX];
      end else begin
        lanes_nxt[l].x   = in_lanes[l].x - dx[l];
        lanes_nxt[l].y   = in_lanes[l].y + dy[l];
        lanes_nxt[l].ang = in_lanes[l].ang - ATAN_DEG_Q24[IDX];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    lanes_r <= lanes_nxt;
  end

  assign out_valid = valid_r;
  assign out_lanes = lanes_r;

endmodule

// File: design/ata_finish.sv
// Rounding, sign, saturation and special cases of the two angles.
module ata_finish (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  ata_pkg::cordic_pair_t in_lanes,
  output logic                out_valid,
  output logic signed [15:0]  out_roll_deg,
  output logic signed [15:0]  out_pitch_deg
);
  import ata_pkg::*;

  logic               valid_r;
  logic signed [15:0] roll_r;
  logic signed [15:0] pitch_r;
  ang_t               ang_s [NUM_LANES];
  ang_t               sum   [NUM_LANES];
  logic signed [16:0] q     [NUM_LANES];
  logic signed [16:0] res   [NUM_LANES];

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      ang_s[l] = (l == LANE_PITCH) ? -in_lanes[l].ang : in_lanes[l].ang;
      sum[l]   = ang_s[l] + ROUND_HALF;
      q[l]     = sum[l][AW-1:16];
      if (in_lanes[l].den_zero) begin
        if (in_lanes[l].num_zero) begin
          res[l] = '0;
        end else if (in_lanes[l].num_neg) begin
          res[l] = -DEG90_Q8;
        end else begin
          res[l] = DEG90_Q8;
        end
        if (l == LANE_PITCH) begin
          res[l] = -res[l];
        end
      end else if (q[l] > DEG90_Q8) begin
        res[l] = DEG90_Q8;
      end else if (q[l] < -DEG90_Q8) begin
        res[l] = -DEG90_Q8;
      end else begin
        res[l] = q[l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    roll_r  <= res[LANE_ROLL][15:0];
    pitch_r <= res[LANE_PITCH][15:0];
  end

  assign out_valid     = valid_r;
  assign out_roll_deg  = roll_r;
  assign out_pitch_deg = pitch_r;

endmodule

// File: design/accel_tilt_angles_unit.sv
// Top level of the accelerometer tilt angle unit.
// The unit takes one three-axis sample per clock cycle and never raises busy.
// Each accepted item passes an input register that holds the sums of squares,
// then 32 cells of the square root chain that produce one root bit each, then
// CORDIC_STAGES cells that rotate the vector and one cell that rounds and
// saturates. Results appear in acceptance order on out_valid for a single
// cycle and must be taken then, since the receiver cannot stall the chain.
module accel_tilt_angles_unit #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_accel_x,
  input  logic signed [15:0] in_accel_y,
  input  logic signed [15:0] in_accel_z,
  output logic               out_valid,
  output logic signed [15:0] out_roll_deg,
  output logic signed [15:0] out_pitch_deg
);
  import ata_pkg::*;

  localparam int LATENCY = CORDIC_STAGES + SQRT_STEPS + 2;

  logic signed [31:0] px;
  logic signed [31:0] py;
  logic signed [31:0] pz;
  logic               in_valid_r;
  sqrt_pair_t         in_lanes_r;
  sqrt_pair_t         in_lanes_nxt;
  logic               sq_valid [SQRT_STEPS+1];
  sqrt_pair_t         sq_lanes [SQRT_STEPS+1];
  logic               co_valid [CORDIC_STAGES+1];
  cordic_pair_t       co_lanes [CORDIC_STAGES+1];

  assign busy = 1'b0;

  always_comb begin
    px = in_accel_x * in_accel_x;
    py = in_accel_y * in_accel_y;
    pz = in_accel_z * in_accel_z;
    in_lanes_nxt[LANE_ROLL].rad       = $unsigned(px) + $unsigned(pz);
    in_lanes_nxt[LANE_ROLL].rem       = '0;
    in_lanes_nxt[LANE_ROLL].root      = '0;
    in_lanes_nxt[LANE_ROLL].num       = in_accel_y;
    in_lanes_nxt[LANE_ROLL].den_zero  = (in_accel_x == 16'sd0) && (in_accel_z == 16'sd0);
    in_lanes_nxt[LANE_PITCH].rad      = $unsigned(py) + $unsigned(pz);
    in_lanes_nxt[LANE_PITCH].rem      = '0;
    in_lanes_nxt[LANE_PITCH].root     = '0;
    in_lanes_nxt[LANE_PITCH].num      = in_accel_x;
    in_lanes_nxt[LANE_PITCH].den_zero = (in_accel_y == 16'sd0) && (in_accel_z == 16'sd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    in_lanes_r <= in_lanes_nxt;
  end

  assign sq_valid[0] = in_valid_r;
  assign sq_lanes[0] = in_lanes_r;

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    ata_sqrt_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (sq_valid[k]),
      .in_lanes  (sq_lanes[k]),
      .out_valid (sq_valid[k+1]),
      .out_lanes (sq_lanes[k+1])
    );
  end

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      co_lanes[0][l].x        = {3'b000, sq_lanes[SQRT_STEPS][l].root};
      co_lanes[0][l].y        = {{3{sq_lanes[SQRT_STEPS][l].num[15]}},
                                 sq_lanes[SQRT_STEPS][l].num, 16'h0000};
      co_lanes[0][l].ang      = '0;
      co_lanes[0][l].den_zero = sq_lanes[SQRT_STEPS][l].den_zero;
      co_lanes[0][l].num_zero = (sq_lanes[SQRT_STEPS][l].num == 16'sd0);
      co_lanes[0][l].num_neg  = sq_lanes[SQRT_STEPS][l].num[15];
    end
  end

  assign co_valid[0] = sq_valid[SQRT_STEPS];

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    ata_cordic_cell #(
      .IDX (i)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (co_valid[i]),
      .in_lanes  (co_lanes[i]),
      .out_valid (co_valid[i+1]),
      .out_lanes (co_lanes[i+1])
    );
  end

  ata_finish u_finish (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (co_valid[CORDIC_STAGES]),
    .in_lanes      (co_lanes[CORDIC_STAGES]),
    .out_valid     (out_valid),
    .out_roll_deg  (out_roll_deg),
    .out_pitch_deg (out_pitch_deg)
  );

`ifndef NO_ASSERTIONS
  a_result_follows_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LATENCY))
    else $error("result without an accepted item");

  a_roll_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_roll_deg <= 16'sd23040 && out_roll_deg >= -16'sd23040))
    else $error("roll out of range");

  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pitch_deg <= 16'sd23040 && out_pitch_deg >= -16'sd23040))
    else $error("pitch out of range");

  a_zero_sample: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(in_accel_x == 16'sd0 && in_accel_y == 16'sd0 &&
                        in_accel_z == 16'sd0, LATENCY))
    |-> (out_roll_deg == 16'sd0 && out_pitch_deg == 16'sd0))
    else $error("zero sample gave nonzero angles");
`endif

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the accelerometer tilt angle unit, with its own angle predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ata_pkg::*;

  localparam int CORDIC_STAGES = 16;
  localparam int LATENCY       = CORDIC_STAGES + 34;
  localparam int RANDOM_ITEMS  = 1950;
  localparam int NUM_DIRECTED  = 23;

  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
  } angle_pair_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic               roll_typed;
    logic signed [15:0] roll;
    logic               pitch_typed;
    logic signed [15:0] pitch;
  } sample_row_t;

  // A typed field holds the angle known by inspection; the rest use the predictor.
  localparam sample_row_t DIRECTED_SAMPLES [NUM_DIRECTED] = '{
    '{16'sd0,      16'sd0,      16'sd0,      1'b1, 16'sd0,      1'b1, 16'sd0},
    '{16'sd0,      16'sh7FFF,   16'sd0,      1'b1, 16'sd23040,  1'b0, 16'sd0},
    '{16'sd0,      16'sh8000,   16'sd0,      1'b1, -16'sd23040, 1'b0, 16'sd0},
    '{16'sh7FFF,   16'sd0,      16'sd0,      1'b0, 16'sd0,      1'b1, -16'sd23040},
    '{16'sh8000,   16'sd0,      16'sd0,      1'b0, 16'sd0,      1'b1, 16'sd23040},
    '{16'sd1,      16'sd0,      16'sd0,      1'b0, 16'sd0,      1'b1, -16'sd23040},
    '{16'sd0,      16'sd1,      16'sd0,      1'b1, 16'sd23040,  1'b0, 16'sd0},
    '{16'sd0,      -16'sd1,     16'sd0,      1'b1, -16'sd23040, 1'b0, 16'sd0},
    '{-16'sd1,     16'sd0,      16'sd0,      1'b0, 16'sd0,      1'b1, 16'sd23040},
    '{16'sd0,      16'sd0,      16'sh7FFF,   1'b0, 16'sd0,      1'b0, 16'sd0},
    '{16'sd0,      16'sd0,      16'sh8000,   1'b0, 16'sd0,      1'b0, 16'sd0},
    '{16'sh7FFF,   16'sh7FFF,   16'sh7FFF,   1'b0, 16'sd0,      1'b0, 16'sd0},
    '{16'sh8000,   16'sh8000,   16'sh8000,   1'b0, 16'sd0,      1'b0, 16'sd0},
    '{16'sh8000,   16'sh7FFF,   16'sh8000,   1'b0, 16'sd0,      1'b0, 16'sd0},
    '{16'sh7FFF,   16'sh8000,   16'sh7FFF,   1'b0, 16'sd0,      1'b0, 16'sd0},
    '{16'sd1,      16'sh7FFF,   16'sd0,      1'b0, 16'sd0,      1'b0, 16'sd0},
    '{-16'sd1,     16'sh8000,   16'sd0,      1'b0, 16'sd0,      1'b0, 16'sd0},
    '{16'sh7FFF,   16'sd1,      16'sd0,      1'b0, 16'sd0,      1'b0, 16'sd0},
    '{16'sh8000,   16'sd0,      16'sd1,      1'b0, 16'sd0,      1'b0, 16'sd0},
    '{16'sd1,      16'sd1,      16'sd1,      1'b0, 16'sd0,      1'b0, 16'sd0},
    '{-16'sd1,     -16'sd1,     -16'sd1,     1'b0, 16'sd0,      1'b0, 16'sd0},
    '{16'sd0,      16'sd0,      16'sd16384,  1'b0, 16'sd0,      1'b0, 16'sd0},
    '{16'sd11585,  16'sd0,      16'sd11585,  1'b0, 16'sd0,      1'b0, 16'sd0}
  };

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic signed [15:0] in_accel_x = '0;
  logic signed [15:0] in_accel_y = '0;
  logic signed [15:0] in_accel_z = '0;
  logic               out_valid;
  logic signed [15:0] out_roll_deg;
  logic signed [15:0] out_pitch_deg;

  angle_pair_t expected_angles [$];
  int          mismatches = 0;
  int          burst_left = 0;

  accel_tilt_angles_unit #(
    .CORDIC_STAGES(CORDIC_STAGES)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_accel_x   (in_accel_x),
    .in_accel_y   (in_accel_y),
    .in_accel_z   (in_accel_z),
    .out_valid    (out_valid),
    .out_roll_deg (out_roll_deg),
    .out_pitch_deg(out_pitch_deg)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Angle of atan2(num, sqrt(a^2 + b^2)) in 1/256 degree, from an exact root and a CORDIC.
  function automatic logic signed [15:0] tilt_angle_q8(input longint num, input longint a,
                                                       input longint b, input bit negate);
    longint unsigned rem;
    longint unsigned root;
    longint unsigned bitv;
    longint          xr;
    longint          yr;
    longint          ang;
    longint          res;
    longint          dx;
    longint          dy;
    rem  = longint'(a * a + b * b) << 32;
    root = 0;
    bitv = 64'd1 << 62;
    ang  = 0;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem  = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    xr = longint'(root);
    yr = num * 65536;
    if (xr == 0) begin
      if (yr == 0) res = 0;
      else res = (yr > 0) ? longint'(DEG90_Q8) : -longint'(DEG90_Q8);
      if (negate) res = -res;
      return res[15:0];
    end
    for (int i = 0; i < CORDIC_STAGES && i < ATAN_LEN; i++) begin
      dx = yr >>> i;
      dy = xr >>> i;
      if (yr >= 0) begin
        xr  = xr + dx;
        yr  = yr - dy;
        ang = ang + longint'(ATAN_DEG_Q24[i]);
      end else begin
        xr  = xr - dx;
        yr  = yr + dy;
        ang = ang - longint'(ATAN_DEG_Q24[i]);
      end
    end
    if (negate) ang = -ang;
    res = (ang + 32768) >>> 16;
    if (res > longint'(DEG90_Q8)) res = longint'(DEG90_Q8);
    if (res < -longint'(DEG90_Q8)) res = -longint'(DEG90_Q8);
    return res[15:0];
  endfunction

  function automatic angle_pair_t predict_angles(input logic signed [15:0] x,
                                                 input logic signed [15:0] y,
                                                 input logic signed [15:0] z);
    angle_pair_t p;
    p.roll  = tilt_angle_q8(longint'(y), longint'(x), longint'(z), 1'b0);
    p.pitch = tilt_angle_q8(longint'(x), longint'(y), longint'(z), 1'b1);
    return p;
  endfunction

  function automatic logic signed [15:0] random_axis(input int mode);
    logic signed [15:0] extremes [7];
    extremes = '{16'sh8000, 16'sh8001, -16'sd1, 16'sd0, 16'sd1, 16'sh7FFE, 16'sh7FFF};
    case (mode)
      0: return 16'($urandom_range(0, 65535));
      1: return 16'(int'($urandom_range(0, 32)) - 16);
      2: return extremes[$urandom_range(0, 6)];
      3: return 16'(int'($urandom_range(0, 40000)) - 20000);
      default: return 16'sd0;
    endcase
  endfunction

  task automatic send_sample(input logic signed [15:0] x, input logic signed [15:0] y,
                             input logic signed [15:0] z, input angle_pair_t want);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 60);
      gap = $urandom_range(0, 7);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start      <= 1'b1;
    in_accel_x <= x;
    in_accel_y <= y;
    in_accel_z <= z;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_angles.push_back(want);
  endtask

  always @(posedge clk) begin : check_results
    angle_pair_t want;
    if (rst_n && out_valid) begin
      if (expected_angles.size() == 0) begin
        report_mismatch($sformatf("unexpected result roll=%0d pitch=%0d",
                                  out_roll_deg, out_pitch_deg));
      end else begin
        want = expected_angles.pop_front();
        if (out_roll_deg !== want.roll)
          report_mismatch($sformatf("roll got %0d want %0d", out_roll_deg, want.roll));
        if (out_pitch_deg !== want.pitch)
          report_mismatch($sformatf("pitch got %0d want %0d", out_pitch_deg, want.pitch));
      end
    end
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    sample_row_t        row;
    angle_pair_t        want;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    int                 kind;
    int                 drain;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED_SAMPLES[i]) begin
      row  = DIRECTED_SAMPLES[i];
      want = predict_angles(row.x, row.y, row.z);
      if (row.roll_typed) want.roll = row.roll;
      if (row.pitch_typed) want.pitch = row.pitch;
      send_sample(row.x, row.y, row.z, want);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1, 2, 3: begin
          x = random_axis(0);
          y = random_axis(0);
          z = random_axis(0);
        end
        4: begin
          x = random_axis(1);
          y = random_axis(1);
          z = random_axis(1);
        end
        5: begin
          x = random_axis($urandom_range(0, 1) ? 0 : 4);
          y = random_axis($urandom_range(0, 1) ? 0 : 4);
          z = random_axis($urandom_range(0, 1) ? 0 : 4);
        end
        6: begin
          x = random_axis(2);
          y = random_axis(2);
          z = random_axis(2);
        end
        default: begin
          x = random_axis(3);
          y = random_axis(3);
          z = random_axis(3);
        end
      endcase
      send_sample(x, y, z, predict_angles(x, y, z));
    end
    start <= 1'b0;

    drain = 0;
    while (expected_angles.size() != 0 && drain < 4 * LATENCY + 100) begin
      @(posedge clk);
      drain++;
    end
    if (expected_angles.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_angles.size()));
    repeat (LATENCY + 8) @(posedge clk);

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/ata_pkg.sv
design/ata_sqrt_cell.sv
design/ata_cordic_cell.sv
design/ata_finish.sv
design/accel_tilt_angles_unit.sv
tb/tb_top.sv
